// ===== rtl/xcfp_pkg.sv =====
// xcfp_pkg: constants, phase and status codes and the result type of the
// XOR-checked frame parser. No dependencies.
package xcfp_pkg;

    localparam logic [7:0] START_BYTE  = 8'h06;
    localparam logic [7:0] STOP_BYTE   = 8'h07;
    localparam logic [7:0] MAX_PAYLOAD = 8'd16;

    // parser phases
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_CMD  = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_CHK  = 3'd4;
    localparam logic [2:0] PH_STOP = 3'd5;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_CHECK  = 2'd1;
    localparam status_t ST_NOSTOP = 2'd2;
    localparam status_t ST_BADLEN = 2'd3;

    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] value;
        logic [7:0]  payload_length;
        status_t     status;
    } result_t;

endpackage

// ===== rtl/xcfp_if.sv =====
// xcfp_in_if / xcfp_out_if: valid/ready channels for received bytes and
// frame results. Depends on xcfp_pkg for the status type.
interface xcfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfp_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        command;
    logic [15:0]       value;
    logic [7:0]        payload_length;
    xcfp_pkg::status_t status;

    modport source (output valid, output command, output value, output payload_length,
                    output status, input ready);
    modport sink   (input valid, input command, input value, input payload_length,
                    input status, output ready);
endinterface

// ===== rtl/xor_checked_frame_parser.sv =====
// xor_checked_frame_parser: top level, parser core plus result buffer.
// Depends on xcfp_pkg, xcfp_if, xcfp_core and xcfp_out_buf.
//
//  channel | dir | payload                                     | handshake
//  --------+-----+---------------------------------------------+-----------
//  rx      | in  | rx_byte[7:0]                                | valid/ready
//  res     | out | command[7:0] value[15:0] payload_length[7:0] | valid/ready
//          |     | status[1:0]                                 |
//
// One byte item per cycle while rx.ready is high. A byte is stepped through
// the parser in the cycle it is accepted; any result item enters a two-entry
// buffer and is shown on res once older ones are taken. rx.ready drops only
// while both buffer entries hold results not yet taken. Reset (rst_n low,
// asynchronous) puts the parser in start-byte hunting and empties the buffer.
module xor_checked_frame_parser (
    input logic       clk,
    input logic       rst_n,
    xcfp_in_if.sink   rx,
    xcfp_out_if.source res
);
    import xcfp_pkg::*;

    logic    take;
    logic    core_valid;
    result_t core_res;
    result_t buf_res;
    logic    room;

    // a byte is taken only while the buffer can hold the one result it may cause
    assign rx.ready = room;
    assign take     = rx.valid && room;

    xcfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx.rx_byte),
        .res_valid (core_valid),
        .res       (core_res)
    );

    xcfp_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_valid),
        .push_data (core_res),
        .has_room  (room),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (buf_res)
    );

    assign res.command        = buf_res.command;
    assign res.value          = buf_res.value;
    assign res.payload_length = buf_res.payload_length;
    assign res.status         = buf_res.status;

endmodule

// ===== rtl/xcfp_core.sv =====
// xcfp_core: frame parser state registers and the one-byte step logic.
// Depends on xcfp_pkg.
module xcfp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output xcfp_pkg::result_t res
);
    import xcfp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [7:0]  command_hold_reg, command_hold_next;
    logic [15:0] value_hold_reg, value_hold_next;
    logic [7:0]  parity_acc_reg, parity_acc_next;
    logic [7:0]  idx;
    logic [7:0]  left_dec;

    assign idx      = frame_length_reg - bytes_left_reg;
    assign left_dec = bytes_left_reg - 8'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        frame_length_next = frame_length_reg;
        command_hold_next = command_hold_reg;
        value_hold_next   = value_hold_reg;
        parity_acc_next   = parity_acc_reg;
        res_valid         = 1'b0;
        res               = '{command: command_hold_reg, value: value_hold_reg,
                              payload_length: frame_length_reg, status: ST_OK};
        if (take)
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    frame_length_next = rx_byte;
                    parity_acc_next   = parity_acc_reg ^ rx_byte;
                    if (rx_byte == 8'd0 || rx_byte > MAX_PAYLOAD)
                    begin
                        res_valid  = 1'b1;
                        res        = '{command: 8'd0, value: 16'd0,
                                       payload_length: rx_byte, status: ST_BADLEN};
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        bytes_left_next = rx_byte;
                        phase_next      = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    command_hold_next = rx_byte;
                    parity_acc_next   = parity_acc_reg ^ rx_byte;
                    value_hold_next   = 16'd0;
                    phase_next        = PH_PAY;
                end
                PH_PAY:
                begin
                    parity_acc_next = parity_acc_reg ^ rx_byte;
                    if (frame_length_reg == 8'd1)
                        value_hold_next = {8'd0, rx_byte};
                    else if (idx == 8'd0)
                        value_hold_next = {rx_byte, 8'd0};
                    else if (idx == 8'd1)
                        value_hold_next = {value_hold_reg[15:8], rx_byte};
                    bytes_left_next = left_dec;
                    if (left_dec == 8'd0)
                        phase_next = PH_CHK;
                end
                PH_CHK:
                begin
                    parity_acc_next = parity_acc_reg ^ rx_byte;
                    phase_next      = PH_STOP;
                end
                PH_STOP:
                begin
                    res_valid  = 1'b1;
                    phase_next = PH_HUNT;
                    if (rx_byte != STOP_BYTE)
                        res.status = ST_NOSTOP;
                    else if (parity_acc_reg != 8'd0)
                        res.status = ST_CHECK;
                end
                default:
                begin
                    // hunting; unused codes fall back here too
                    phase_next = PH_HUNT;
                    if (rx_byte == START_BYTE)
                    begin
                        parity_acc_next = START_BYTE;
                        phase_next      = PH_LEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            bytes_left_reg   <= 8'd0;
            frame_length_reg <= 8'd0;
            command_hold_reg <= 8'd0;
            value_hold_reg   <= 16'd0;
            parity_acc_reg   <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            frame_length_reg <= frame_length_next;
            command_hold_reg <= command_hold_next;
            value_hold_reg   <= value_hold_next;
            parity_acc_reg   <= parity_acc_next;
        end
    end

    // results come only from the length or stop phase
    a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (phase_reg == PH_LEN || phase_reg == PH_STOP))
        else $error("result outside length/stop phase");

    // every result sends the parser back to hunting
    a_res_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after a result");

    // payload phase always has bytes still to come
    a_pay_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (bytes_left_reg != 8'd0))
        else $error("payload phase with no bytes left");

endmodule

// ===== rtl/xcfp_out_buf.sv =====
// xcfp_out_buf: two-entry result buffer between the parser and the result
// channel. Depends on xcfp_pkg.
module xcfp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  xcfp_pkg::result_t push_data,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output xcfp_pkg::result_t out_data
);
    import xcfp_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("buffer count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("buffer pointers disagree with count");

endmodule
